>>> design/spq_pkg.sv
// Package for the strict-priority queue block: sizes, field types, codes and
// the minute-of-day helper shared by the control, result and top-level files.
// Depends on nothing.
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TICKET_BITS = 16;
	localparam int COUNT_BITS  = 16;

	localparam int NUM_CLASSES      = 4;
	localparam int CLASS_W          = 2;
	localparam int TICKET_IN_W      = 16;
	localparam int HOUR_W           = 5;
	localparam int MIN_W            = 6;
	localparam int MOD_W            = 11;
	localparam int WAIT_W           = 12;
	localparam int LONG_W           = 11;
	localparam int MINUTES_PER_HOUR = 60;

	localparam int PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int TOT_W    = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1);
	localparam int TKT_W    = (TICKET_BITS < TICKET_IN_W) ? TICKET_BITS : TICKET_IN_W;
	localparam int ADDR_W   = CLASS_W + PTR_W;
	localparam int MEM_DEPTH = NUM_CLASSES * (2 ** PTR_W);

	// Payload field types of the two channels.
	typedef logic [1:0]             kind_field_t;
	typedef logic [TICKET_IN_W-1:0] ticket_in_t;
	typedef logic [CLASS_W-1:0]     cls_t;
	typedef logic [HOUR_W-1:0]      hour_t;
	typedef logic [MIN_W-1:0]       min_t;
	typedef logic [15:0]            ticket_out_t;
	typedef logic signed [WAIT_W-1:0] wait_t;
	typedef logic [4:0]             cw_out_t;
	typedef logic [15:0]            cs_out_t;
	typedef logic [6:0]             tw_out_t;
	typedef logic [15:0]            ts_out_t;
	typedef logic [6:0]             pk_out_t;
	typedef logic [LONG_W-1:0]      long_t;

	// Internal types.
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [PTR_W:0]        sum_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [TOT_W-1:0]      tot_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [TKT_W-1:0]      ticket_t;
	typedef logic [MOD_W-1:0]      mod_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		KIND_ARRIVE = 2'd0,
		KIND_SERVE  = 2'd1,
		KIND_QUERY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_QUEUED  = 3'd0,
		ST_DROPPED = 3'd1,
		ST_SERVED  = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_QUERY   = 3'd4
	} status_t;

	typedef struct packed {
		ticket_t ticket;
		hour_t   hour;
		min_t    minute;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Everything the result stage needs besides the entry read from the store.
	typedef struct packed {
		status_t status;
		cls_t    cls;
		cnt_t    class_waiting;
		count_t  class_served;
		tot_t    total_waiting;
		count_t  total_served;
		tot_t    peak_waiting;
		mod_t    now_min;
	} s1_t;

	function automatic mod_t minute_of_day(input hour_t h, input min_t m);
		return mod_t'(h) * mod_t'(MINUTES_PER_HOUR) + mod_t'(m);
	endfunction

endpackage

>>> design/spq_if.sv
// Valid/ready channel interfaces of the strict-priority queue block.
// Depends on spq_pkg for the field types.
interface spq_req_if;
	logic                valid;
	logic                ready;
	spq_pkg::kind_field_t kind;
	spq_pkg::ticket_in_t ticket;
	spq_pkg::cls_t       class_in;
	spq_pkg::hour_t      hour;
	spq_pkg::min_t       minute;

	modport source (output valid, kind, ticket, class_in, hour, minute, input ready);
	modport sink (input valid, kind, ticket, class_in, hour, minute, output ready);
endinterface

interface spq_rsp_if;
	logic                 valid;
	logic                 ready;
	spq_pkg::status_t     status;
	spq_pkg::ticket_out_t ticket_out;
	spq_pkg::cls_t        class_out;
	spq_pkg::wait_t       wait_minutes;
	spq_pkg::cw_out_t     class_waiting;
	spq_pkg::cs_out_t     class_served;
	spq_pkg::tw_out_t     total_waiting;
	spq_pkg::ts_out_t     total_served;
	spq_pkg::pk_out_t     peak_waiting;
	spq_pkg::long_t       longest_wait;

	modport source (output valid, status, ticket_out, class_out, wait_minutes,
		class_waiting, class_served, total_waiting, total_served, peak_waiting,
		longest_wait, input ready);
	modport sink (input valid, status, ticket_out, class_out, wait_minutes,
		class_waiting, class_served, total_waiting, total_served, peak_waiting,
		longest_wait, output ready);
endinterface

>>> design/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/spq_ctrl.sv
// Queue control: per-class head pointers and counts, statistics counters, the
// priority pick, entry store addressing and the first pipeline register.
// Depends on spq_pkg and spq_req_if.
module spq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	spq_req_if.sink         req,
	input  logic            take,
	output logic            valid_s1,
	output spq_pkg::s1_t    stage_s1,
	output logic            mem_we,
	output spq_pkg::addr_t  mem_waddr,
	output spq_pkg::entry_t mem_wdata,
	output logic            mem_re,
	output spq_pkg::addr_t  mem_raddr
);

	spq_pkg::ptr_t   head_q [spq_pkg::NUM_CLASSES];
	spq_pkg::cnt_t   cnt_q  [spq_pkg::NUM_CLASSES];
	spq_pkg::count_t srv_q  [spq_pkg::NUM_CLASSES];
	spq_pkg::count_t tsrv_q;
	spq_pkg::tot_t   total_q;
	spq_pkg::tot_t   peak_q;

	spq_pkg::ptr_t   head_d [spq_pkg::NUM_CLASSES];
	spq_pkg::cnt_t   cnt_d  [spq_pkg::NUM_CLASSES];
	spq_pkg::count_t srv_d  [spq_pkg::NUM_CLASSES];
	spq_pkg::count_t tsrv_d;
	spq_pkg::tot_t   total_d;
	spq_pkg::tot_t   peak_d;

	logic            acc;
	logic            load_s1;
	logic            found;
	spq_pkg::cls_t   pick;
	spq_pkg::cls_t   cls_in;
	spq_pkg::sum_t   tail_sum;
	spq_pkg::ptr_t   tail;
	spq_pkg::s1_t    s1_d;

	function automatic spq_pkg::count_t sat_inc(input spq_pkg::count_t v);
		return (v == spq_pkg::COUNT_MAX) ? v : v + 1'b1;
	endfunction

	assign req.ready = !valid_s1 || take;
	assign acc       = req.valid && req.ready;
	assign cls_in    = req.class_in;

	// Lowest class number with anything waiting wins.
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int c = spq_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
			if (cnt_q[c] != '0) begin
				found = 1'b1;
				pick  = spq_pkg::cls_t'(c);
			end
		end
	end

	assign tail_sum = spq_pkg::sum_t'(head_q[cls_in]) + spq_pkg::sum_t'(cnt_q[cls_in]);
	assign tail = (tail_sum >= spq_pkg::sum_t'(spq_pkg::QUEUE_DEPTH))
		? spq_pkg::ptr_t'(tail_sum - spq_pkg::sum_t'(spq_pkg::QUEUE_DEPTH))
		: spq_pkg::ptr_t'(tail_sum);

	always_comb begin
		head_d    = head_q;
		cnt_d     = cnt_q;
		srv_d     = srv_q;
		tsrv_d    = tsrv_q;
		total_d   = total_q;
		peak_d    = peak_q;
		load_s1   = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = {cls_in, tail};
		mem_raddr = {pick, head_q[pick]};
		mem_wdata = '{ticket: spq_pkg::ticket_t'(req.ticket), hour: req.hour,
			minute: req.minute};
		s1_d      = '0;
		if (acc) begin
			case (spq_pkg::kind_t'(req.kind))
				spq_pkg::KIND_ARRIVE: begin
					load_s1  = 1'b1;
					s1_d.cls = cls_in;
					if (cnt_q[cls_in] >= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH)) begin
						s1_d.status = spq_pkg::ST_DROPPED;
					end else begin
						s1_d.status   = spq_pkg::ST_QUEUED;
						mem_we        = 1'b1;
						cnt_d[cls_in] = cnt_q[cls_in] + 1'b1;
						total_d       = total_q + 1'b1;
						if (total_d > peak_q) begin
							peak_d = total_d;
						end
					end
					s1_d.class_waiting = cnt_d[cls_in];
					s1_d.class_served  = srv_q[cls_in];
				end
				spq_pkg::KIND_SERVE: begin
					load_s1 = 1'b1;
					if (!found) begin
						s1_d.status = spq_pkg::ST_EMPTY;
					end else begin
						s1_d.status  = spq_pkg::ST_SERVED;
						mem_re       = 1'b1;
						head_d[pick] = (head_q[pick] == spq_pkg::ptr_t'(spq_pkg::QUEUE_DEPTH - 1))
							? '0 : head_q[pick] + 1'b1;
						cnt_d[pick]  = cnt_q[pick] - 1'b1;
						srv_d[pick]  = sat_inc(srv_q[pick]);
						tsrv_d       = sat_inc(tsrv_q);
						total_d      = total_q - 1'b1;
						s1_d.cls           = pick;
						s1_d.class_waiting = cnt_d[pick];
						s1_d.class_served  = srv_d[pick];
					end
				end
				spq_pkg::KIND_QUERY: begin
					load_s1            = 1'b1;
					s1_d.status        = spq_pkg::ST_QUERY;
					s1_d.cls           = cls_in;
					s1_d.class_waiting = cnt_q[cls_in];
					s1_d.class_served  = srv_q[cls_in];
				end
				default: begin
					load_s1 = 1'b0;
				end
			endcase
		end
		s1_d.total_waiting = total_d;
		s1_d.total_served  = tsrv_d;
		s1_d.peak_waiting  = peak_d;
		s1_d.now_min       = spq_pkg::minute_of_day(req.hour, req.minute);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				cnt_q[c]  <= '0;
				srv_q[c]  <= '0;
			end
			tsrv_q   <= '0;
			total_q  <= '0;
			peak_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			srv_q   <= srv_d;
			tsrv_q  <= tsrv_d;
			total_q <= total_d;
			peak_q  <= peak_d;
			if (acc) begin
				valid_s1 <= load_s1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stage_s1 <= s1_d;
		end
	end

`ifndef ASSERT_OFF
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == spq_pkg::tot_t'(cnt_q[0]) + spq_pkg::tot_t'(cnt_q[1])
			+ spq_pkg::tot_t'(cnt_q[2]) + spq_pkg::tot_t'(cnt_q[3]))
		else $error("total occupancy differs from the sum of class counts");

	a_peak_covers_total: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= total_q)
		else $error("peak occupancy below current occupancy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH)
			&& cnt_q[1] <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH)
			&& cnt_q[2] <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH)
			&& cnt_q[3] <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH))
		else $error("class count above queue depth");

	a_serve_pops: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.kind == spq_pkg::KIND_SERVE && found
			|=> valid_s1 && stage_s1.status == spq_pkg::ST_SERVED)
		else $error("service with a waiting client did not pop");
`endif

endmodule

>>> design/spq_result.sv
// Result stage: wait computation from the entry read out of the store, the
// longest-wait register and the output register of the response channel.
// Depends on spq_pkg and spq_rsp_if.
module spq_result (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  spq_pkg::s1_t    stage_s1,
	input  spq_pkg::entry_t rd_entry,
	output logic            take,
	spq_rsp_if.source       rsp
);

	spq_pkg::long_t max_q;
	spq_pkg::long_t max_d;
	spq_pkg::mod_t  arr_min;
	spq_pkg::wait_t wait_v;
	logic           served;
	logic           load;

	assign take    = !rsp.valid || rsp.ready;
	assign load    = valid_s1 && take;
	assign served  = stage_s1.status == spq_pkg::ST_SERVED;
	assign arr_min = spq_pkg::minute_of_day(rd_entry.hour, rd_entry.minute);
	assign wait_v  = spq_pkg::wait_t'(stage_s1.now_min) - spq_pkg::wait_t'(arr_min);

	// A negative wait is reported but never counts toward the longest wait.
	always_comb begin
		max_d = max_q;
		if (served && !wait_v[spq_pkg::WAIT_W-1]
			&& spq_pkg::long_t'(wait_v) > max_q) begin
			max_d = spq_pkg::long_t'(wait_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q     <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (load) begin
				max_q <= max_d;
			end
			if (take) begin
				rsp.valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp.status        <= stage_s1.status;
			rsp.ticket_out    <= served ? spq_pkg::ticket_out_t'(rd_entry.ticket) : '0;
			rsp.class_out     <= stage_s1.cls;
			rsp.wait_minutes  <= served ? wait_v : '0;
			rsp.class_waiting <= spq_pkg::cw_out_t'(stage_s1.class_waiting);
			rsp.class_served  <= spq_pkg::cs_out_t'(stage_s1.class_served);
			rsp.total_waiting <= spq_pkg::tw_out_t'(stage_s1.total_waiting);
			rsp.total_served  <= spq_pkg::ts_out_t'(stage_s1.total_served);
			rsp.peak_waiting  <= spq_pkg::pk_out_t'(stage_s1.peak_waiting);
			rsp.longest_wait  <= max_d;
		end
	end

endmodule

>>> design/strict_priority_queue_stats.sv
// Channel   Dir  Beat contents
// req       in   kind, ticket, class_in, hour, minute
// rsp       out  status, ticket_out, class_out, wait_minutes, class and total stats
//
// One request beat is taken every cycle unless the middle stage is full and rsp stalls.
// The accepting edge updates pointers, counts, the middle stage and the entry store read;
// the output register then loads the wait and longest-wait results once rsp can take them.
// A stalled rsp holds the output register; req.ready stays high while the middle stage
// can drain, so a request is still taken while one response waits.
// Reset clears all counters at once; the entry store needs no clearing pass.
// Top level: ties the queue control, the entry store RAM and the result stage together.
// Depends on spq_pkg, spq_if, spq_ram, spq_ctrl and spq_result.
module strict_priority_queue_stats (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic            take;
	logic            valid_s1;
	spq_pkg::s1_t    stage_s1;
	logic            mem_we;
	spq_pkg::addr_t  mem_waddr;
	spq_pkg::entry_t mem_wdata;
	logic            mem_re;
	spq_pkg::addr_t  mem_raddr;
	spq_pkg::entry_t rd_entry;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.take      (take),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (spq_pkg::MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_entry)
	);

	spq_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.rd_entry (rd_entry),
		.take     (take),
		.rsp      (rsp)
	);

endmodule

>>> tb/tb_strict_priority_queue_stats.sv
// Self-checking testbench for strict_priority_queue_stats: drives arrival, service and query
// beats under several flow-control mixes and checks every response against its own predictor.
// Depends on spq_pkg, spq_if and the block's RTL.
module tb_strict_priority_queue_stats;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DAY_MINUTES = 1440;
	localparam int PHASE_ITEMS = 230;
	localparam spq_pkg::kind_field_t KIND_UNUSED = 2'd3;

	typedef struct packed {
		spq_pkg::status_t     status;
		spq_pkg::ticket_out_t ticket_out;
		spq_pkg::cls_t        class_out;
		spq_pkg::wait_t       wait_min;
		spq_pkg::cw_out_t     class_waiting;
		spq_pkg::cs_out_t     class_served;
		spq_pkg::tw_out_t     total_waiting;
		spq_pkg::ts_out_t     total_served;
		spq_pkg::pk_out_t     peak_waiting;
		spq_pkg::long_t       longest_wait;
	} queue_result_t;

	typedef struct {
		spq_pkg::ticket_in_t ticket;
		spq_pkg::hour_t      hour;
		spq_pkg::min_t       minute;
	} slot_rec_t;

	function automatic string show_result(queue_result_t r);
		return $sformatf({"status=%0d ticket=%h class=%0d wait=%0d cw=%0d cs=%0d ",
			"tw=%0d ts=%0d peak=%0d longest=%0d"}, r.status, r.ticket_out, r.class_out,
			$signed(r.wait_min), r.class_waiting, r.class_served, r.total_waiting,
			r.total_served, r.peak_waiting, r.longest_wait);
	endfunction

	class queue_scoreboard;
		slot_rec_t        slots[spq_pkg::NUM_CLASSES][spq_pkg::QUEUE_DEPTH];
		int               head[spq_pkg::NUM_CLASSES];
		int               fill[spq_pkg::NUM_CLASSES];
		spq_pkg::count_t  served[spq_pkg::NUM_CLASSES];
		spq_pkg::count_t  served_all;
		int               peak;
		int               longest;
		queue_result_t    expected_q[$];
		int               errors, n_checked;
		int               n_arrive, n_dropped, n_serve, n_empty, n_query, n_ignored;

		function new();
			foreach (served[c])
				served[c] = '0;
			served_all = '0;
		endfunction

		function int occupancy();
			int sum;
			sum = 0;
			foreach (fill[c])
				sum += fill[c];
			return sum;
		endfunction

		function void note_request(spq_pkg::kind_field_t k, spq_pkg::ticket_in_t t,
			spq_pkg::cls_t c, spq_pkg::hour_t h, spq_pkg::min_t m);
			queue_result_t r;
			int pick, arr, now, w;
			slot_rec_t e;
			r = '0;
			if (k == KIND_UNUSED) begin
				n_ignored++;
				return;
			end
			case (k)
				spq_pkg::KIND_ARRIVE: begin
					n_arrive++;
					r.class_out = c;
					if (fill[c] >= spq_pkg::QUEUE_DEPTH) begin
						r.status = spq_pkg::ST_DROPPED;
						n_dropped++;
					end else begin
						slots[c][(head[c] + fill[c]) % spq_pkg::QUEUE_DEPTH] = '{t, h, m};
						fill[c]++;
						if (occupancy() > peak)
							peak = occupancy();
						r.status = spq_pkg::ST_QUEUED;
					end
					r.class_waiting = spq_pkg::cw_out_t'(fill[c]);
					r.class_served  = served[c];
				end
				spq_pkg::KIND_SERVE: begin
					n_serve++;
					pick = -1;
					for (int i = spq_pkg::NUM_CLASSES - 1; i >= 0; i--)
						if (fill[i] != 0)
							pick = i;
					if (pick < 0) begin
						r.status = spq_pkg::ST_EMPTY;
						n_empty++;
					end else begin
						e = slots[pick][head[pick]];
						arr = int'(e.hour) * spq_pkg::MINUTES_PER_HOUR + int'(e.minute);
						now = int'(h) * spq_pkg::MINUTES_PER_HOUR + int'(m);
						w = now - arr;
						if (w > longest)
							longest = w;
						head[pick] = (head[pick] + 1) % spq_pkg::QUEUE_DEPTH;
						fill[pick]--;
						if (served[pick] != spq_pkg::COUNT_MAX)
							served[pick]++;
						if (served_all != spq_pkg::COUNT_MAX)
							served_all++;
						r.status        = spq_pkg::ST_SERVED;
						r.ticket_out    = spq_pkg::ticket_out_t'(e.ticket);
						r.class_out     = spq_pkg::cls_t'(pick);
						r.wait_min      = spq_pkg::wait_t'(w);
						r.class_waiting = spq_pkg::cw_out_t'(fill[pick]);
						r.class_served  = served[pick];
					end
				end
				default: begin
					n_query++;
					r.status        = spq_pkg::ST_QUERY;
					r.class_out     = c;
					r.class_waiting = spq_pkg::cw_out_t'(fill[c]);
					r.class_served  = served[c];
				end
			endcase
			r.total_waiting = spq_pkg::tw_out_t'(occupancy());
			r.total_served  = served_all;
			r.peak_waiting  = spq_pkg::pk_out_t'(peak);
			r.longest_wait  = spq_pkg::long_t'(longest);
			expected_q.push_back(r);
		endfunction

		function void check_response(queue_result_t got);
			queue_result_t want;
			string bad;
			n_checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Response with nothing pending: %s", show_result(got));
				return;
			end
			want = expected_q.pop_front();
			bad = "";
			if (got.status !== want.status) bad = {bad, " status"};
			if (got.ticket_out !== want.ticket_out) bad = {bad, " ticket_out"};
			if (got.class_out !== want.class_out) bad = {bad, " class_out"};
			if (got.wait_min !== want.wait_min) bad = {bad, " wait_minutes"};
			if (got.class_waiting !== want.class_waiting) bad = {bad, " class_waiting"};
			if (got.class_served !== want.class_served) bad = {bad, " class_served"};
			if (got.total_waiting !== want.total_waiting) bad = {bad, " total_waiting"};
			if (got.total_served !== want.total_served) bad = {bad, " total_served"};
			if (got.peak_waiting !== want.peak_waiting) bad = {bad, " peak_waiting"};
			if (got.longest_wait !== want.longest_wait) bad = {bad, " longest_wait"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("Mismatch at %0t in%s", $time, bad);
					$display("  expected %s", show_result(want));
					$display("  actual   %s", show_result(got));
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	strict_priority_queue_stats u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	queue_scoreboard sb = new();
	queue_result_t   seen;
	int              send_idle_pct;
	int              stall_pct;
	int              clock_min;
	int              cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles", cycles);
		$display("FAILURE");
		$finish;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready) begin
			seen.status        = rsp_ch.status;
			seen.ticket_out    = rsp_ch.ticket_out;
			seen.class_out     = rsp_ch.class_out;
			seen.wait_min      = rsp_ch.wait_minutes;
			seen.class_waiting = rsp_ch.class_waiting;
			seen.class_served  = rsp_ch.class_served;
			seen.total_waiting = rsp_ch.total_waiting;
			seen.total_served  = rsp_ch.total_served;
			seen.peak_waiting  = rsp_ch.peak_waiting;
			seen.longest_wait  = rsp_ch.longest_wait;
			sb.check_response(seen);
		end
	end

	function automatic spq_pkg::ticket_in_t rand_ticket();
		return spq_pkg::ticket_in_t'($urandom);
	endfunction

	function automatic spq_pkg::cls_t rand_class();
		return spq_pkg::cls_t'($urandom_range(3));
	endfunction

	// Holds the beat until it is taken, then optionally leaves a random gap.
	task automatic send_req(spq_pkg::kind_field_t k, spq_pkg::ticket_in_t t, spq_pkg::cls_t c,
		spq_pkg::hour_t h, spq_pkg::min_t m);
		int gap;
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= k;
		req_ch.ticket   <= t;
		req_ch.class_in <= c;
		req_ch.hour     <= h;
		req_ch.minute   <= m;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(k, t, c, h, m);
		gap = 0;
		while (int'($urandom_range(99)) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Time mostly moves forward through the day and wraps at midnight, which gives
	// negative waits; some beats carry any hour and minute the fields can hold.
	task automatic next_time(output spq_pkg::hour_t h, output spq_pkg::min_t m);
		if ($urandom_range(99) < 15) begin
			h = spq_pkg::hour_t'($urandom_range(31));
			m = spq_pkg::min_t'($urandom_range(63));
		end else begin
			clock_min = (clock_min + int'($urandom_range(0, 6))) % DAY_MINUTES;
			h = spq_pkg::hour_t'(clock_min / spq_pkg::MINUTES_PER_HOUR);
			m = spq_pkg::min_t'(clock_min % spq_pkg::MINUTES_PER_HOUR);
		end
	endtask

	// Fill every class past its depth, then drain everything and ask twice more.
	task automatic flood_all();
		spq_pkg::hour_t h;
		spq_pkg::min_t m;
		for (int c = 0; c < spq_pkg::NUM_CLASSES; c++)
			repeat (spq_pkg::QUEUE_DEPTH + 2) begin
				next_time(h, m);
				send_req(spq_pkg::KIND_ARRIVE, rand_ticket(), spq_pkg::cls_t'(c), h, m);
			end
		repeat (spq_pkg::NUM_CLASSES * spq_pkg::QUEUE_DEPTH + 2) begin
			next_time(h, m);
			send_req(spq_pkg::KIND_SERVE, rand_ticket(), rand_class(), h, m);
		end
	endtask

	task automatic run_traffic(int n_items);
		int done, len, r;
		spq_pkg::cls_t c;
		spq_pkg::hour_t h;
		spq_pkg::min_t m;
		done = 0;
		while (done < n_items) begin
			r = int'($urandom_range(99));
			if (r < 40) begin
				len = int'($urandom_range(1, 20));
				c = rand_class();
				repeat (len) begin
					next_time(h, m);
					send_req(spq_pkg::KIND_ARRIVE, rand_ticket(), c, h, m);
				end
				done += len;
			end else if (r < 75) begin
				len = int'($urandom_range(1, 12));
				repeat (len) begin
					next_time(h, m);
					send_req(spq_pkg::KIND_SERVE, rand_ticket(), rand_class(), h, m);
				end
				done += len;
			end else if (r < 95) begin
				next_time(h, m);
				send_req((r < 85) ? spq_pkg::KIND_ARRIVE : spq_pkg::KIND_QUERY, rand_ticket(),
					rand_class(), h, m);
				done++;
			end else begin
				send_req(KIND_UNUSED, rand_ticket(), rand_class(),
					spq_pkg::hour_t'($urandom_range(31)), spq_pkg::min_t'($urandom_range(63)));
			end
		end
	endtask

	task automatic run_phase(int idle_pct, int busy_pct);
		send_idle_pct = idle_pct;
		stall_pct     = busy_pct;
		flood_all();
		run_traffic(PHASE_ITEMS);
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.kind     = spq_pkg::KIND_QUERY;
		req_ch.ticket   = '0;
		req_ch.class_in = '0;
		req_ch.hour     = '0;
		req_ch.minute   = '0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		clock_min       = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty service and query, one arrival per class, then serve them in priority order
		// for a zero wait, a negative wait, the largest wait and the most negative wait.
		send_req(spq_pkg::KIND_SERVE, 16'h0000, 2'd0, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_QUERY, 16'h0000, 2'd3, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_ARRIVE, 16'hFFFF, 2'd3, 5'd31, 6'd63);
		send_req(spq_pkg::KIND_ARRIVE, 16'h0000, 2'd0, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_ARRIVE, 16'h1234, 2'd1, 5'd23, 6'd59);
		send_req(spq_pkg::KIND_ARRIVE, 16'hA5A5, 2'd2, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_QUERY, 16'hFFFF, 2'd0, 5'd31, 6'd63);
		send_req(spq_pkg::KIND_QUERY, 16'h5A5A, 2'd1, 5'd12, 6'd30);
		send_req(spq_pkg::KIND_SERVE, 16'h0000, 2'd3, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_SERVE, 16'h0000, 2'd0, 5'd0, 6'd5);
		send_req(spq_pkg::KIND_SERVE, 16'hFFFF, 2'd1, 5'd31, 6'd63);
		send_req(KIND_UNUSED, 16'hFFFF, 2'd3, 5'd31, 6'd63);
		send_req(spq_pkg::KIND_SERVE, 16'h0000, 2'd2, 5'd0, 6'd0);
		send_req(spq_pkg::KIND_SERVE, 16'h0000, 2'd0, 5'd12, 6'd0);
		send_req(spq_pkg::KIND_QUERY, 16'h0000, 2'd2, 5'd0, 6'd0);

		run_phase(0, 0);
		run_phase(75, 0);
		run_phase(0, 75);
		run_phase(12, 12);

		send_idle_pct = 0;
		stall_pct     = 0;
		for (int c = 0; c < spq_pkg::NUM_CLASSES; c++)
			send_req(spq_pkg::KIND_QUERY, rand_ticket(), spq_pkg::cls_t'(c), 5'd0, 6'd0);
		req_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d arrivals (%0d dropped), %0d service requests (%0d on empty queues),",
			sb.n_arrive, sb.n_dropped, sb.n_serve, sb.n_empty);
		$display("%0d queries and %0d ignored beats; %0d responses checked, %0d errors.",
			sb.n_query, sb.n_ignored, sb.n_checked, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
